// ----- hdl/binary_to_decimal_ascii_emitter_defines.svh -----
// ============================================================================
// Assertion macros for the binary to decimal ASCII emitter
// Implication checks on the rising edge of clk, held off during reset.
// ============================================================================
`ifndef BINARY_TO_DECIMAL_ASCII_EMITTER_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_EMITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define B2DA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2da check failed");
`define B2DA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2da check failed");
`else
`define B2DA_ASSERT_SAME(label, ante, cons)
`define B2DA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/b2da_pkg.sv -----
// ============================================================================
// b2da_pkg
// Types, constants and the double-dabble digit adjust for the emitter.
// ============================================================================
package b2da_pkg;

    typedef logic [3:0] digit_t;
    typedef logic [5:0] char_t;

    localparam char_t ASCII_ZERO         = 6'd48;
    localparam int    DD_BITS_PER_STAGE  = 4;

    function automatic digit_t dd_adjust(input digit_t d);
        return (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
    endfunction

endpackage

// ----- hdl/binary_to_decimal_ascii_emitter.sv -----
// ============================================================================
// binary_to_decimal_ascii_emitter
// Converts an unsigned binary number to ASCII decimal digits, most
// significant first, leading zeros suppressed, last digit marked.
//
//   channel | signals                          | role
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_ready, value        | one number per beat
//   out     | out_valid, out_ready,            | one digit per beat, last_digit
//           | digit_char, last_digit           | set on the final digit
//
// A number passes a double-dabble pipeline of ceil(VALUE_BITS/4) stages, four
// bits per stage, and can enter in every cycle while the pipeline has room.
// The digit shifter then steps through all NDIG digit positions of a number
// (10 at 32 bits) unless out stalls, dropping leading zeros as it goes, so the
// shifter sets the sustained rate. A stall on out fills the pipeline and then
// holds in_ready low; nothing is lost or repeated. Reset empties all stages.
// ============================================================================
`include "binary_to_decimal_ascii_emitter_defines.svh"

module binary_to_decimal_ascii_emitter
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            digit_char,
    output logic                  last_digit
);

    localparam int NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int STAGES = (VALUE_BITS + DD_BITS_PER_STAGE - 1) / DD_BITS_PER_STAGE;
    localparam int PAD_W  = STAGES * DD_BITS_PER_STAGE;
    localparam int CNT_W  = $clog2(NDIG + 1);

    logic [STAGES-1:0] vld_reg;
    logic [BCD_W-1:0]  bcd_reg [STAGES];
    logic [PAD_W-1:0]  bin_reg [STAGES];
    logic [STAGES:0]   load;

    logic [BCD_W-1:0]  dig_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              started_reg;
    logic              emit_take;
    digit_t            top_digit;

    assign in_ready = load[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [BCD_W-1:0] bcd_in;
        logic [PAD_W-1:0] bin_in;
        logic             vld_in;
        logic [BCD_W-1:0] bcd_c;
        logic [PAD_W-1:0] bin_c;

        if (k == 0) begin : g_first
            assign bcd_in = '0;
            assign bin_in = PAD_W'(value);
            assign vld_in = in_valid;
        end
        else begin : g_next
            assign bcd_in = bcd_reg[k-1];
            assign bin_in = bin_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign load[k] = !vld_reg[k] || load[k+1];

        always_comb
        begin
            bcd_c = bcd_in;
            bin_c = bin_in;
            for (int b = 0; b < DD_BITS_PER_STAGE; b++)
            begin
                for (int d = 0; d < NDIG; d++)
                begin
                    bcd_c[d*4 +: 4] = dd_adjust(bcd_c[d*4 +: 4]);
                end
                bcd_c = {bcd_c[BCD_W-2:0], bin_c[PAD_W-1]};
                bin_c = {bin_c[PAD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (load[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                bcd_reg[k] <= bcd_c;
                bin_reg[k] <= bin_c;
            end
        end
    end

    assign top_digit  = dig_reg[BCD_W-1 -: 4];
    assign out_valid  = busy_reg && (started_reg || (top_digit != 4'd0) ||
                                     (cnt_reg == CNT_W'(1)));
    assign last_digit = (cnt_reg == CNT_W'(1));
    assign digit_char = ASCII_ZERO + char_t'(top_digit);
    assign emit_take  = !busy_reg || (out_valid && out_ready && last_digit);
    assign load[STAGES] = emit_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            dig_reg     <= '0;
        end
        else if (emit_take)
        begin
            busy_reg    <= vld_reg[STAGES-1];
            started_reg <= 1'b0;
            cnt_reg     <= CNT_W'(NDIG);
            dig_reg     <= bcd_reg[STAGES-1];
        end
        else if (!out_valid || out_ready)
        begin
            started_reg <= started_reg || out_valid;
            cnt_reg     <= cnt_reg - CNT_W'(1);
            dig_reg     <= {dig_reg[BCD_W-5:0], 4'd0};
        end
    end

    `B2DA_ASSERT_SAME(a_busy_has_count, busy_reg, cnt_reg != '0)
    `B2DA_ASSERT_SAME(a_no_leading_zero, out_valid && !started_reg && !last_digit, top_digit != '0)
    `B2DA_ASSERT_NEXT(a_last_restarts, out_valid && out_ready && last_digit, !started_reg)
    `B2DA_ASSERT_NEXT(a_in_enters_pipe, in_valid && in_ready, vld_reg[0])

endmodule
